@@ hdl/rwh_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rwh_pkg;

  localparam int unsigned TagWidth = 32;
  localparam int unsigned PosWidth = 33;

  localparam logic [TagWidth-1:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [TagWidth-1:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [TagWidth-1:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [TagWidth-1:0] TAG_DATA = 32'h6461_7461;

  // Byte positions within the file header
  localparam logic [PosWidth-1:0] RIFF_LAST_POS = 33'd3;
  localparam logic [PosWidth-1:0] WAVE_LAST_POS = 33'd11;

  localparam logic [31:0] FMT_MIN_SIZE = 32'd16;
  localparam logic [15:0] FORMAT_PCM   = 16'd1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_WAVE  = 3'd1;
  localparam logic [2:0] ST_TRUNCATED = 3'd2;
  localparam logic [2:0] ST_FMT_SHORT = 3'd3;
  localparam logic [2:0] ST_NOT_PCM   = 3'd4;
  localparam logic [2:0] ST_MISSING   = 3'd5;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [15:0] sample_bits;
    logic [31:0] audio_start;
    logic [31:0] audio_length;
  } result_t;

endpackage

`default_nettype wire

@@ hdl/rwh_in_reg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rwh_in_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [7:0]       file_byte,
  input  wire logic             end_of_file,
  input  wire logic             hold,
  output logic                  item_valid,
  output rwh_pkg::in_item_t     item
);

  logic              valid;
  rwh_pkg::in_item_t data;

  // Block new requests only while the held byte cannot advance
  assign in_stall   = valid && hold;
  assign item_valid = valid;
  assign item       = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!in_stall) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      data.file_byte   <= file_byte;
      data.end_of_file <= end_of_file;
    end
  end

endmodule

`default_nettype wire

@@ hdl/rwh_parse.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rwh_parse (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire rwh_pkg::in_item_t item,
  output rwh_pkg::result_t       result
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_CHUNK_HEAD,
    PH_BODY,
    PH_STOP
  } phase_t;

  phase_t      phase, phase_next;
  logic [32:0] byte_position, byte_position_next;
  logic [31:0] tag_shift, tag_shift_next;
  logic [31:0] chunk_size, chunk_size_next;
  logic [32:0] chunk_body_count, chunk_body_count_next;
  logic        chunk_is_fmt, chunk_is_fmt_next;
  logic [15:0] format_code, format_code_next;
  logic [15:0] pending_channels, pending_channels_next;
  logic [31:0] pending_rate, pending_rate_next;
  logic [15:0] pending_bits, pending_bits_next;
  logic [15:0] held_channels, held_channels_next;
  logic [31:0] held_rate, held_rate_next;
  logic [15:0] held_bits, held_bits_next;
  logic [31:0] held_audio_start, held_audio_start_next;
  logic [31:0] held_audio_length, held_audio_length_next;
  logic        seen_fmt, seen_fmt_next;
  logic        seen_data, seen_data_next;
  logic [2:0]  latched_error, latched_error_next;

  logic        fail;
  logic [2:0]  fail_code;
  logic        finish;
  logic [7:0]  b;
  logic [32:0] body_total;
  logic [32:0] body_count_inc;
  logic        pos_at_limit;
  logic [2:0]  status;

  assign b              = item.file_byte;
  assign pos_at_limit   = byte_position[32] || (&byte_position[31:0]);
  assign body_total     = {1'b0, chunk_size} + {32'd0, chunk_size[0]};
  assign body_count_inc = chunk_body_count + 33'd1;

  always_comb begin
    phase_next             = phase;
    byte_position_next     = byte_position;
    tag_shift_next         = tag_shift;
    chunk_size_next        = chunk_size;
    chunk_body_count_next  = chunk_body_count;
    chunk_is_fmt_next      = chunk_is_fmt;
    format_code_next       = format_code;
    pending_channels_next  = pending_channels;
    pending_rate_next      = pending_rate;
    pending_bits_next      = pending_bits;
    held_channels_next     = held_channels;
    held_rate_next         = held_rate;
    held_bits_next         = held_bits;
    held_audio_start_next  = held_audio_start;
    held_audio_length_next = held_audio_length;
    seen_fmt_next          = seen_fmt;
    seen_data_next         = seen_data;
    latched_error_next     = latched_error;
    fail                   = 1'b0;
    fail_code              = rwh_pkg::ST_OK;
    finish                 = 1'b0;

    if (phase != PH_STOP) begin
      if (pos_at_limit) begin
        fail      = 1'b1;
        fail_code = rwh_pkg::ST_TRUNCATED;
      end else begin
        case (phase)
          PH_HEADER: begin
            tag_shift_next = {tag_shift[23:0], b};
            if (byte_position == rwh_pkg::RIFF_LAST_POS &&
                tag_shift_next != rwh_pkg::TAG_RIFF) begin
              fail      = 1'b1;
              fail_code = rwh_pkg::ST_NOT_WAVE;
            end else if (byte_position == rwh_pkg::WAVE_LAST_POS) begin
              if (tag_shift_next != rwh_pkg::TAG_WAVE) begin
                fail      = 1'b1;
                fail_code = rwh_pkg::ST_NOT_WAVE;
              end else begin
                phase_next            = PH_CHUNK_HEAD;
                chunk_body_count_next = 33'd0;
              end
            end
          end
          PH_CHUNK_HEAD: begin
            // Tag bytes first, then the little-endian size
            if (!chunk_body_count[2]) begin
              tag_shift_next = {tag_shift[23:0], b};
              if (chunk_body_count[1:0] == 2'd0) begin
                chunk_size_next = 32'd0;
              end
            end else begin
              case (chunk_body_count[1:0])
                2'd0:    chunk_size_next[7:0]   = b;
                2'd1:    chunk_size_next[15:8]  = b;
                2'd2:    chunk_size_next[23:16] = b;
                default: chunk_size_next[31:24] = b;
              endcase
            end
            chunk_body_count_next = body_count_inc;
            if (chunk_body_count[2:0] == 3'd7) begin
              chunk_is_fmt_next = (tag_shift == rwh_pkg::TAG_FMT);
              if (tag_shift == rwh_pkg::TAG_DATA) begin
                held_audio_start_next  = byte_position[31:0] + 32'd1;
                held_audio_length_next = chunk_size_next;
                seen_data_next         = 1'b1;
              end
              chunk_body_count_next = 33'd0;
              phase_next            = PH_BODY;
              finish                = (chunk_size_next == 32'd0);
            end
          end
          PH_BODY: begin
            if (chunk_is_fmt && chunk_body_count[32:4] == 29'd0) begin
              case (chunk_body_count[3:0])
                4'd0:    format_code_next[7:0]       = b;
                4'd1:    format_code_next[15:8]      = b;
                4'd2:    pending_channels_next[7:0]  = b;
                4'd3:    pending_channels_next[15:8] = b;
                4'd4:    pending_rate_next[7:0]      = b;
                4'd5:    pending_rate_next[15:8]     = b;
                4'd6:    pending_rate_next[23:16]    = b;
                4'd7:    pending_rate_next[31:24]    = b;
                4'd14:   pending_bits_next[7:0]      = b;
                4'd15:   pending_bits_next[15:8]     = b;
                default: ;
              endcase
            end
            chunk_body_count_next = body_count_inc;
            finish                = (body_count_inc >= body_total);
          end
          default: ;
        endcase
      end
    end

    // Close the chunk: apply fmt checks and commit its fields
    if (finish) begin
      if (chunk_is_fmt_next) begin
        if (chunk_size_next < rwh_pkg::FMT_MIN_SIZE) begin
          fail      = 1'b1;
          fail_code = rwh_pkg::ST_FMT_SHORT;
        end else if (format_code_next != rwh_pkg::FORMAT_PCM) begin
          fail      = 1'b1;
          fail_code = rwh_pkg::ST_NOT_PCM;
        end else begin
          held_channels_next = pending_channels_next;
          held_rate_next     = pending_rate_next;
          held_bits_next     = pending_bits_next;
          seen_fmt_next      = 1'b1;
        end
      end
      if (!fail) begin
        phase_next            = PH_CHUNK_HEAD;
        chunk_body_count_next = 33'd0;
      end
    end

    // Keep the first error and stop parsing
    if (fail) begin
      if (latched_error == rwh_pkg::ST_OK) begin
        latched_error_next = fail_code;
      end
      phase_next = PH_STOP;
    end

    if (!byte_position[32]) begin
      byte_position_next = byte_position + 33'd1;
    end
  end

  always_comb begin
    case (phase_next)
      PH_STOP:   status = latched_error_next;
      PH_HEADER: status = rwh_pkg::ST_NOT_WAVE;
      PH_BODY:   status = rwh_pkg::ST_TRUNCATED;
      default: begin
        if (!seen_fmt_next || !seen_data_next || held_channels_next == 16'd0 ||
            held_rate_next == 32'd0 || held_bits_next == 16'd0) begin
          status = rwh_pkg::ST_MISSING;
        end else begin
          status = rwh_pkg::ST_OK;
        end
      end
    endcase
  end

  assign result.status        = status;
  assign result.channel_count = held_channels_next;
  assign result.sample_rate   = held_rate_next;
  assign result.sample_bits   = held_bits_next;
  assign result.audio_start   = held_audio_start_next;
  assign result.audio_length  = held_audio_length_next;

  // The last byte of a file returns everything to reset for the next file
  always_ff @(posedge clk) begin
    if (rst || (step && item.end_of_file)) begin
      phase             <= PH_HEADER;
      byte_position     <= 33'd0;
      tag_shift         <= 32'd0;
      chunk_size        <= 32'd0;
      chunk_body_count  <= 33'd0;
      chunk_is_fmt      <= 1'b0;
      format_code       <= 16'd0;
      pending_channels  <= 16'd0;
      pending_rate      <= 32'd0;
      pending_bits      <= 16'd0;
      held_channels     <= 16'd0;
      held_rate         <= 32'd0;
      held_bits         <= 16'd0;
      held_audio_start  <= 32'd0;
      held_audio_length <= 32'd0;
      seen_fmt          <= 1'b0;
      seen_data         <= 1'b0;
      latched_error     <= rwh_pkg::ST_OK;
    end else if (step) begin
      phase             <= phase_next;
      byte_position     <= byte_position_next;
      tag_shift         <= tag_shift_next;
      chunk_size        <= chunk_size_next;
      chunk_body_count  <= chunk_body_count_next;
      chunk_is_fmt      <= chunk_is_fmt_next;
      format_code       <= format_code_next;
      pending_channels  <= pending_channels_next;
      pending_rate      <= pending_rate_next;
      pending_bits      <= pending_bits_next;
      held_channels     <= held_channels_next;
      held_rate         <= held_rate_next;
      held_bits         <= held_bits_next;
      held_audio_start  <= held_audio_start_next;
      held_audio_length <= held_audio_length_next;
      seen_fmt          <= seen_fmt_next;
      seen_data         <= seen_data_next;
      latched_error     <= latched_error_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/rwh_out_reg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rwh_out_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire rwh_pkg::result_t result,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output rwh_pkg::result_t      q
);

  logic             valid;
  rwh_pkg::result_t data;

  assign out_valid = valid;
  assign q         = data;

  // Load only when empty or draining in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (!out_stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= result;
    end
  end

endmodule

`default_nettype wire

@@ hdl/riff_wave_header_parser.sv @@
// RIFF/WAVE PCM header parser.
// Input channel: one file byte per request (file_byte), with end_of_file high
// on the last byte of a file. The block checks the RIFF and WAVE tags, walks the
// chunks by their little-endian sizes (odd chunks carry a pad byte), captures
// channels, sample rate and bits from fmt chunks and body offset and length from
// data chunks. Later chunks of either kind replace earlier ones.
// Output channel: exactly one result per file, on its last byte, carrying a
// status code and the held fields; other bytes produce no result.
// Throughput: one byte per cycle, set by the single register-to-register pass
// of the parse logic, except while a last byte is held (see Stall). The last
// byte goes through the input register and then the result register, whose
// load raises out_valid; the load waits while that byte is held.
// Stall: while a result waits under out_stall, ordinary bytes keep flowing;
// only the last byte of the next file is held in the input register, and
// in_stall rises once that register is occupied.
// Reset (rst, synchronous): clears both registers' valid flags and puts the
// parser at the start of a file. After each last byte the parser also returns
// to that state, so files may follow back to back.
`timescale 1ns / 1ps
`default_nettype none

module riff_wave_header_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  file_byte,
  input  wire logic        end_of_file,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       status,
  output logic [15:0]      channel_count,
  output logic [31:0]      sample_rate,
  output logic [15:0]      sample_bits,
  output logic [31:0]      audio_start,
  output logic [31:0]      audio_length
);

  logic              item_valid;
  rwh_pkg::in_item_t item;
  logic              hold;
  logic              step;
  rwh_pkg::result_t  result;
  rwh_pkg::result_t  out_q;

  // Hold a last byte while the previous result is still stuck downstream
  assign hold = item.end_of_file && out_valid && out_stall;
  assign step = item_valid && !hold;

  rwh_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .file_byte   (file_byte),
    .end_of_file (end_of_file),
    .hold        (hold),
    .item_valid  (item_valid),
    .item        (item)
  );

  // Advance the parse state by one byte
  rwh_parse u_parse (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (item),
    .result (result)
  );

  rwh_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (step && item.end_of_file),
    .result    (result),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .q         (out_q)
  );

  assign status        = out_q.status;
  assign channel_count = out_q.channel_count;
  assign sample_rate   = out_q.sample_rate;
  assign sample_bits   = out_q.sample_bits;
  assign audio_start   = out_q.audio_start;
  assign audio_length  = out_q.audio_length;

endmodule

`default_nettype wire
